@@ design/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that also holds while reset is high.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ design/ncr_pkg.sv @@
// Constants shared by the negative color redistribution core and its checker.
// Depends on nothing.
`timescale 1ns / 1ps

package ncr_pkg;

   // Channel order on the ports: blue, green, red.
   localparam int NUM_CH      = 3;
   localparam int CH_BLUE     = 0;
   localparam int CH_GREEN    = 1;
   localparam int CH_RED      = 2;

   // Gain register.
   localparam int GAIN_W      = 10;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd280;

   // Output code width and soft clip constants.
   localparam int OUT_W       = 8;
   localparam int CLIP_STEPS  = OUT_W;
   localparam int CLIP_SCALE  = 510;   // twice the full output code, for rounding
   localparam int PCT_SCALE   = 100;   // percent

   // Extra fraction bits in the norm, as a shift of the sum of squares.
   localparam int NORM_SHIFT  = 14;

   typedef logic [OUT_W-1:0] out_code_type;

endpackage

@@ design/negative_color_redistribution_core.sv @@
// Negative color redistribution core: one pixel per clock, fully pipelined.
// Depends on ncr_pkg.
//
//   port group | direction | beat contents
//   req_       | in        | blue_in, green_in, red_in (signed SAMPLE_WIDTH)
//   rsp_       | out       | blue_out, green_out, red_out (8 bit)
//   csr_       | in        | gain_percent (10 bit)
//
// A new pixel can enter every clock unless a stall backs the pipe up. Most stages
// are the square root pipeline (one root bit per stage) and the rescale divider
// (one quotient bit per stage), followed by an 8 stage soft clip divider.
// Reset is synchronous; it clears the valid bits and loads the gain reset value.
// A stall on rsp_ready holds the last stage; stages behind it keep filling
// bubbles, so input is still taken until every stage holds a pixel.
`timescale 1ns / 1ps

module negative_color_redistribution_core #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_blue_in,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_green_in,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_red_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ncr_pkg::OUT_W-1:0]           rsp_blue_out,
   output logic [ncr_pkg::OUT_W-1:0]           rsp_green_out,
   output logic [ncr_pkg::OUT_W-1:0]           rsp_red_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ncr_pkg::GAIN_W-1:0]          csr_gain_percent
);
   import ncr_pkg::*;

   localparam int W    = SAMPLE_WIDTH;
   localparam int F    = W - 2;
   localparam int RW   = W + 1 + NORM_SHIFT / 2;   // root width
   localparam int QW   = W + 1;                    // rescaled channel width
   localparam int DW   = RW + QW;                  // rescale dividend width
   localparam int NGW  = QW + GAIN_W;              // channel times gain
   localparam int DENW = NGW + 1;                  // soft clip denominator
   localparam int CW   = DENW + 9;                 // soft clip dividend

   localparam int ST_IN  = 0;
   localparam int ST_SQ  = 1;
   localparam int ST_SUM = 2;
   localparam int ST_RT0 = 3;
   localparam int ST_MUL = ST_RT0 + RW;
   localparam int ST_DV0 = ST_MUL + 1;
   localparam int ST_SEL = ST_DV0 + QW;
   localparam int ST_ND  = ST_SEL + 1;
   localparam int ST_CL0 = ST_ND + 1;
   localparam int NS     = ST_CL0 + CLIP_STEPS;

   localparam logic [DENW-1:0] CLIP_BASE = DENW'(PCT_SCALE) << F;

   typedef struct packed {
      logic                          use_div;
      logic [NUM_CH-1:0]             pos;
      logic [NUM_CH-1:0][W-1:0]      xp;
      logic [NUM_CH-1:0][W-1:0]      adir;
   } side_type;

   // ------------------------------------------------------------------
   // Handshake: a stage advances when it is empty or the one after it does.
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_shift;
   logic [NS:0]   adv;

   always_comb begin
      adv[NS] = rsp_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign v_shift   = {v_ff[NS-2:0], req_valid};
   assign req_ready = adv[ST_IN];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_shift[k];
            end
         end
      end
   end

   // Gain register; the user must write configuration only while the pipe is idle; the block has no check for it.
   logic [GAIN_W-1:0] gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_valid) begin
         gain_ff <= csr_gain_percent;
      end
   end

   // ------------------------------------------------------------------
   // Input register.
   logic [W-1:0] x0_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         x0_ff[CH_BLUE]  <= req_blue_in;
         x0_ff[CH_GREEN] <= req_green_in;
         x0_ff[CH_RED]   <= req_red_in;
      end
   end

   // ------------------------------------------------------------------
   // Classify the pixel, take magnitudes and squares, and form the
   // complementary color for an all non-positive pixel.
   logic [NUM_CH-1:0]        neg_s1;
   logic [NUM_CH-1:0]        pos_s1;
   logic [NUM_CH-1:0][W-1:0] mag_s1;
   logic [NUM_CH-1:0][W-1:0] comp_s1;
   logic [W-1:0]             mx_s1;
   logic [W-1:0]             mn_s1;
   logic                     nonneg_s1;
   logic                     nonpos_s1;
   logic [2*W-1:0]           sq1_ff [NUM_CH];
   side_type                 side1_ff;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         neg_s1[i] = x0_ff[i][W-1];
         pos_s1[i] = !x0_ff[i][W-1] && (x0_ff[i] != '0);
         mag_s1[i] = x0_ff[i][W-1] ? (~x0_ff[i] + W'(1)) : x0_ff[i];
      end
      nonneg_s1 = ~|neg_s1;
      nonpos_s1 = ~|pos_s1;
      mx_s1 = mag_s1[0];
      mn_s1 = mag_s1[0];
      for (int i = 1; i < NUM_CH; i++) begin
         if (mag_s1[i] > mx_s1) begin
            mx_s1 = mag_s1[i];
         end
         if (mag_s1[i] < mn_s1) begin
            mn_s1 = mag_s1[i];
         end
      end
      for (int i = 0; i < NUM_CH; i++) begin
         comp_s1[i] = W'(({1'b0, mx_s1} + {1'b0, mn_s1}) - {1'b0, mag_s1[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SQ]) begin
         for (int i = 0; i < NUM_CH; i++) begin
            sq1_ff[i]         <= (2*W)'(mag_s1[i]) * (2*W)'(mag_s1[i]);
            side1_ff.adir[i]  <= nonneg_s1 ? x0_ff[i] : comp_s1[i];
         end
         side1_ff.use_div <= !nonneg_s1 && !nonpos_s1;
         side1_ff.pos     <= pos_s1;
         side1_ff.xp      <= mag_s1;
      end
   end

   // ------------------------------------------------------------------
   // Sums of squares of the original and the clipped pixel.
   logic [2*W+1:0]    o2_s2;
   logic [2*W+1:0]    c2_s2;
   logic [2*RW-1:0]   rad2_ff [2];
   side_type          side2_ff;

   always_comb begin
      o2_s2 = '0;
      c2_s2 = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         o2_s2 = o2_s2 + (2*W+2)'(sq1_ff[i]);
         if (side1_ff.pos[i]) begin
            c2_s2 = c2_s2 + (2*W+2)'(sq1_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SUM]) begin
         rad2_ff[0] <= {o2_s2, NORM_SHIFT'(0)};
         rad2_ff[1] <= {c2_s2, NORM_SHIFT'(0)};
         side2_ff.pos <= side1_ff.pos;
         side2_ff.xp  <= side1_ff.xp;
         // A mixed pixel with no kept energy goes black.
         side2_ff.use_div <= side1_ff.use_div && (c2_s2 != '0);
         side2_ff.adir    <= (side1_ff.use_div && (c2_s2 == '0)) ? '0 : side1_ff.adir;
      end
   end

   // ------------------------------------------------------------------
   // Two square roots side by side, one root bit per stage.
   // Index 0 is the original norm, index 1 the clipped norm.
   logic [RW+1:0]   rt_rem_ff  [RW][2];
   logic [RW-1:0]   rt_root_ff [RW][2];
   logic [2*RW-1:0] rt_rad_ff  [RW][2];
   side_type        rt_side_ff [RW];

   for (genvar s = 0; s < RW; s++) begin : g_rt
      localparam int J = RW - 1 - s;
      logic [RW-1:0]   rem_src  [2];
      logic [RW-1:0]   root_src [2];
      logic [2*RW-1:0] rad_src  [2];
      side_type        side_src;
      logic [RW+1:0]   rem_sh   [2];
      logic [RW+1:0]   trial    [2];
      logic [1:0]      take;

      if (s == 0) begin : g_first
         always_comb begin
            for (int r = 0; r < 2; r++) begin
               rem_src[r]  = '0;
               root_src[r] = '0;
               rad_src[r]  = rad2_ff[r];
            end
            side_src = side2_ff;
         end
      end else begin : g_next
         always_comb begin
            for (int r = 0; r < 2; r++) begin
               rem_src[r]  = rt_rem_ff[s-1][r][RW-1:0];
               root_src[r] = rt_root_ff[s-1][r];
               rad_src[r]  = rt_rad_ff[s-1][r];
            end
            side_src = rt_side_ff[s-1];
         end
      end

      // Bring down the next two radicand bits and try the next root bit.
      always_comb begin
         for (int r = 0; r < 2; r++) begin
            rem_sh[r] = {rem_src[r], rad_src[r][2*J+1 -: 2]};
            trial[r]  = {root_src[r], 2'b01};
            take[r]   = rem_sh[r] >= trial[r];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[ST_RT0+s]) begin
            for (int r = 0; r < 2; r++) begin
               rt_rem_ff[s][r]  <= take[r] ? (rem_sh[r] - trial[r]) : rem_sh[r];
               rt_root_ff[s][r] <= {root_src[r][RW-2:0], take[r]};
               rt_rad_ff[s][r]  <= rad_src[r];
            end
            rt_side_ff[s] <= side_src;
         end
      end
   end

   // ------------------------------------------------------------------
   // Rescale dividend: channel times original norm, plus half the divisor.
   logic [RW-1:0] no_m;
   logic [RW-1:0] nc_m;
   logic [DW-1:0] mul_num_ff [NUM_CH];
   logic [RW-1:0] mul_nc_ff;
   side_type      mul_side_ff;

   assign no_m = rt_root_ff[RW-1][0];
   assign nc_m = rt_root_ff[RW-1][1];

   always_ff @(posedge clock) begin
      if (adv[ST_MUL]) begin
         for (int i = 0; i < NUM_CH; i++) begin
            mul_num_ff[i] <= DW'((W+RW)'(rt_side_ff[RW-1].xp[i]) * (W+RW)'(no_m))
                             + DW'(nc_m >> 1);
         end
         mul_nc_ff   <= nc_m;
         mul_side_ff <= rt_side_ff[RW-1];
      end
   end

   // ------------------------------------------------------------------
   // Restoring divide by the clipped norm, one quotient bit per stage.
   logic [DW-1:0] dv_rem_ff  [QW][NUM_CH];
   logic [QW-1:0] dv_q_ff    [QW][NUM_CH];
   logic [RW-1:0] dv_nc_ff   [QW];
   side_type      dv_side_ff [QW];

   for (genvar t = 0; t < QW; t++) begin : g_dv
      localparam int K = QW - 1 - t;
      logic [DW-1:0] rem_src [NUM_CH];
      logic [QW-1:0] q_src   [NUM_CH];
      logic [RW-1:0] nc_src;
      side_type      side_src;
      logic [DW-1:0] dsh;
      logic [NUM_CH-1:0] take;

      if (t == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < NUM_CH; i++) begin
               rem_src[i] = mul_num_ff[i];
               q_src[i]   = '0;
            end
            nc_src   = mul_nc_ff;
            side_src = mul_side_ff;
         end
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < NUM_CH; i++) begin
               rem_src[i] = dv_rem_ff[t-1][i];
               q_src[i]   = dv_q_ff[t-1][i];
            end
            nc_src   = dv_nc_ff[t-1];
            side_src = dv_side_ff[t-1];
         end
      end

      always_comb begin
         dsh = DW'(nc_src) << K;
         for (int i = 0; i < NUM_CH; i++) begin
            take[i] = rem_src[i] >= dsh;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[ST_DV0+t]) begin
            for (int i = 0; i < NUM_CH; i++) begin
               dv_rem_ff[t][i] <= take[i] ? (rem_src[i] - dsh) : rem_src[i];
               dv_q_ff[t][i]   <= {q_src[i][QW-2:0], take[i]};
            end
            dv_nc_ff[t]   <= nc_src;
            dv_side_ff[t] <= side_src;
         end
      end
   end

   // ------------------------------------------------------------------
   // Pick the corrected channel and apply the gain.
   logic [QW-1:0]  a_sel [NUM_CH];
   logic [NGW-1:0] sel_num_ff [NUM_CH];

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         if (dv_side_ff[QW-1].use_div) begin
            a_sel[i] = dv_side_ff[QW-1].pos[i] ? dv_q_ff[QW-1][i] : '0;
         end else begin
            a_sel[i] = QW'(dv_side_ff[QW-1].adir[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SEL]) begin
         for (int i = 0; i < NUM_CH; i++) begin
            sel_num_ff[i] <= NGW'(a_sel[i]) * NGW'(gain_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // Soft clip operands: 255*v/(1+v) rounded is (510*n + d) / (2*d).
   logic [DENW-1:0] den_nd [NUM_CH];
   logic [CW-1:0]   nd_rem_ff [NUM_CH];
   logic [DENW:0]   nd_d_ff   [NUM_CH];

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         den_nd[i] = DENW'(sel_num_ff[i]) + CLIP_BASE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_ND]) begin
         for (int i = 0; i < NUM_CH; i++) begin
            nd_rem_ff[i] <= CW'(sel_num_ff[i]) * CW'(CLIP_SCALE) + CW'(den_nd[i]);
            nd_d_ff[i]   <= {den_nd[i], 1'b0};
         end
      end
   end

   // ------------------------------------------------------------------
   // Eight step restoring divide gives the output code.
   logic [CW-1:0]   cl_rem_ff [CLIP_STEPS][NUM_CH];
   logic [DENW:0]   cl_d_ff   [CLIP_STEPS][NUM_CH];
   out_code_type    cl_q_ff   [CLIP_STEPS][NUM_CH];

   for (genvar c = 0; c < CLIP_STEPS; c++) begin : g_cl
      localparam int K = CLIP_STEPS - 1 - c;
      logic [CW-1:0]     rem_src [NUM_CH];
      logic [DENW:0]     d_src   [NUM_CH];
      out_code_type      q_src   [NUM_CH];
      logic [CW-1:0]     dsh     [NUM_CH];
      logic [NUM_CH-1:0] take;

      if (c == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < NUM_CH; i++) begin
               rem_src[i] = nd_rem_ff[i];
               d_src[i]   = nd_d_ff[i];
               q_src[i]   = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < NUM_CH; i++) begin
               rem_src[i] = cl_rem_ff[c-1][i];
               d_src[i]   = cl_d_ff[c-1][i];
               q_src[i]   = cl_q_ff[c-1][i];
            end
         end
      end

      always_comb begin
         for (int i = 0; i < NUM_CH; i++) begin
            dsh[i]  = CW'(d_src[i]) << K;
            take[i] = rem_src[i] >= dsh[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[ST_CL0+c]) begin
            for (int i = 0; i < NUM_CH; i++) begin
               cl_rem_ff[c][i] <= take[i] ? (rem_src[i] - dsh[i]) : rem_src[i];
               cl_d_ff[c][i]   <= d_src[i];
               cl_q_ff[c][i]   <= {q_src[i][OUT_W-2:0], take[i]};
            end
         end
      end
   end

   // Output beat comes straight from the last divider stage.
   assign rsp_blue_out  = cl_q_ff[CLIP_STEPS-1][CH_BLUE];
   assign rsp_green_out = cl_q_ff[CLIP_STEPS-1][CH_GREEN];
   assign rsp_red_out   = cl_q_ff[CLIP_STEPS-1][CH_RED];

endmodule

@@ design/ncr_checker.sv @@
// Port level checks for the negative color redistribution core, and its bind.
// Depends on ncr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ncr_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic signed [SAMPLE_WIDTH-1:0]  req_blue_in,
   input logic signed [SAMPLE_WIDTH-1:0]  req_green_in,
   input logic signed [SAMPLE_WIDTH-1:0]  req_red_in,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ncr_pkg::OUT_W-1:0]       rsp_blue_out,
   input logic [ncr_pkg::OUT_W-1:0]       rsp_green_out,
   input logic [ncr_pkg::OUT_W-1:0]       rsp_red_out,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [ncr_pkg::GAIN_W-1:0]      csr_gain_percent
);
   import ncr_pkg::*;

   // The whole result beat as one vector.
   logic [3*OUT_W-1:0] rsp_beat;

   assign rsp_beat = {rsp_blue_out, rsp_green_out, rsp_red_out};

   // The pipe comes out of reset empty.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // With no beat waiting at the output, every stage can move, so input is open.
   `ASSERT_CLKD(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // A consumer that is ready lets the whole pipe advance.
   `ASSERT_CLKD(a_ready_follows, clock, reset, rsp_ready |-> req_ready)

   // A stalled result beat holds its payload.
   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))

endmodule

bind negative_color_redistribution_core ncr_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ncr_checker (.*);

@@ sim/tb.sv @@
// Testbench for the negative color redistribution core: directed and random pixels.
// Depends on ncr_pkg and negative_color_redistribution_core; predicts each beat itself.
`timescale 1ns / 1ps

module tb;
   import ncr_pkg::*;

   localparam int SW = 16;
   localparam int FB = SW - 2;
   localparam int LATENCY = 2 * SW + 23;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [OUT_W-1:0] blue;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] red;
   } color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SW-1:0] req_blue_in = '0;
   logic signed [SW-1:0] req_green_in = '0;
   logic signed [SW-1:0] req_red_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_W-1:0] rsp_blue_out, rsp_green_out, rsp_red_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [GAIN_W-1:0] csr_gain_percent = '0;

   // Testbench copy of the gain register.
   logic [GAIN_W-1:0] gain_now = GAIN_RESET;
   color_type pending_colors[$];
   int mismatches = 0;
   longint cycles = 0;
   bit stall_hold = 1'b0;
   int stall_pattern = 0;
   int burst_left = 0;

   negative_color_redistribution_core #(.SAMPLE_WIDTH(SW)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_blue_in(req_blue_in), .req_green_in(req_green_in), .req_red_in(req_red_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_blue_out(rsp_blue_out), .rsp_green_out(rsp_green_out),
      .rsp_red_out(rsp_red_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_gain_percent(csr_gain_percent)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bitwise integer square root, floor.
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Gain, soft clip v/(1+v) and scale to 255 with half-up rounding.
   function automatic logic [OUT_W-1:0] soft_clip_code(longint level);
      longint unsigned num, den;
      if (level <= 0) return '0;
      num = longint'(level) * gain_now;
      den = 64'd100 * (64'd1 << FB) + num;
      return OUT_W'((64'd510 * num + den) / (2 * den));
   endfunction

   // Predicts the output color of one pixel under the current gain.
   function automatic color_type redistribute_color(logic signed [SW-1:0] b,
         logic signed [SW-1:0] g, logic signed [SW-1:0] r);
      longint x[3], a[3], mx, mn;
      longint unsigned o2, c2, no, nc, m;
      bit nonneg, nonpos;
      color_type c;
      x[0] = b; x[1] = g; x[2] = r;
      nonneg = 1; nonpos = 1;
      for (int i = 0; i < 3; i++) begin
         if (x[i] < 0) nonneg = 0;
         if (x[i] > 0) nonpos = 0;
      end
      if (nonneg) begin
         a = x;
      end else if (nonpos) begin
         // Negate, then take the complementary color.
         mx = -x[0]; mn = -x[0];
         for (int i = 1; i < 3; i++) begin
            if (-x[i] > mx) mx = -x[i];
            if (-x[i] < mn) mn = -x[i];
         end
         for (int i = 0; i < 3; i++) a[i] = mx + mn + x[i];
      end else begin
         // Clip negatives and rescale to keep the original norm.
         o2 = 0; c2 = 0;
         for (int i = 0; i < 3; i++) begin
            m = (x[i] < 0) ? -x[i] : x[i];
            o2 += m * m;
            if (x[i] > 0) c2 += m * m;
         end
         if (c2 == 0) begin
            for (int i = 0; i < 3; i++) a[i] = 0;
         end else begin
            no = int_sqrt(o2 << NORM_SHIFT);
            nc = int_sqrt(c2 << NORM_SHIFT);
            for (int i = 0; i < 3; i++)
               a[i] = (x[i] > 0) ? longint'((longint'(x[i]) * no + nc / 2) / nc) : 0;
         end
      end
      c.blue = soft_clip_code(a[0]);
      c.green = soft_clip_code(a[1]);
      c.red = soft_clip_code(a[2]);
      return c;
   endfunction

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: a stall pattern of its own, or a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_pattern <= stall_pattern + 1;
         case (stall_pattern[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Checks each result beat against the oldest prediction.
   always @(posedge clock) begin
      color_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %0d %0d %0d",
               rsp_blue_out, rsp_green_out, rsp_red_out);
         end else begin
            want = pending_colors.pop_front();
            if (want.blue !== rsp_blue_out || want.green !== rsp_green_out ||
                  want.red !== rsp_red_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     want.blue, want.green, want.red,
                     rsp_blue_out, rsp_green_out, rsp_red_out);
            end
         end
      end
   end

   // Sends one pixel beat, with bursts and random gaps when paced.
   // Valid stays high between beats; a gap or a drain takes it low.
   task automatic send_pixel(int b, int g, int r, bit paced);
      int gap;
      color_type want;
      if (paced) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_blue_in <= SW'(b);
      req_green_in <= SW'(g);
      req_red_in <= SW'(r);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = redistribute_color(SW'(b), SW'(g), SW'(r));
      pending_colors.insert(pending_colors.size(), want);
   endtask

   // Waits until every result has come, then lets the pipeline drain.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Writes the gain register while the block is idle.
   task automatic write_gain(int value);
      drain_results();
      csr_valid <= 1'b1;
      csr_gain_percent <= GAIN_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gain_now = GAIN_W'(value);
      csr_valid <= 1'b0;
   endtask

   function automatic int random_sample();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 16384);
         2: return -int'($urandom_range(0, 16384));
         3: return $urandom_range(0, 40) - 20;
         4: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         default: return 0;
      endcase
   endfunction

   // Field extremes and each sign class under the reset gain.
   task automatic test_directed();
      send_pixel(0, 0, 0, 0);
      send_pixel(32767, 32767, 32767, 0);
      send_pixel(16384, 0, 1, 0);
      send_pixel(-32768, -32768, -32768, 0);
      send_pixel(-32768, -1, 0, 0);
      send_pixel(-100, -5000, -16384, 0);
      send_pixel(-32768, 32767, 0, 0);
      send_pixel(32767, -32768, -32768, 0);
      send_pixel(1, -1, -1, 0);
      send_pixel(-1, 1, 32767, 0);
      send_pixel(12000, -7000, 3000, 0);
      send_pixel(-21845, 21845, -1, 0);
      send_pixel(1, 0, 0, 0);
   endtask

   // Gain extremes, including zero gain.
   task automatic test_gain_extremes();
      int gains[4] = '{0, 1023, 1, 100};
      foreach (gains[k]) begin
         write_gain(gains[k]);
         send_pixel(32767, 16384, 1, 0);
         send_pixel(-32768, -1, -16384, 0);
         send_pixel(20000, -32768, 5, 0);
      end
   endtask

   // Random pixels over several gain settings, sender bursting.
   task automatic test_random_pixels();
      for (int p = 0; p < 4; p++) begin
         write_gain((p == 0) ? 280 : $urandom_range(0, 1023));
         repeat (75) send_pixel(random_sample(), random_sample(), random_sample(), 1);
      end
   endtask

   // Receiver holds off while the sender keeps offering, so input backs up.
   task automatic test_backpressure();
      drain_results();
      stall_hold = 1'b1;
      fork
         repeat (3 * LATENCY) @(posedge clock);
         repeat (80) send_pixel(random_sample(), random_sample(), random_sample(), 0);
      join_any
      stall_hold = 1'b0;
      wait fork;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_gain_extremes();
      test_random_pixels();
      test_backpressure();
      drain_results();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/ncr_pkg.sv
design/negative_color_redistribution_core.sv
design/ncr_checker.sv
sim/tb.sv
